// ===== rtl/tcre_pkg.sv =====
// Shared types, constants and register map of the touch contact report engine.
`timescale 1ns / 1ps

package tcre_pkg;

  localparam int MAX_FINGERS  = 10;
  localparam int FINGER_IDX_W = 4;
  localparam int COUNT_W      = 4;
  localparam int POS_W        = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int NUM_SLOTS    = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_XY     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_ENABLED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REL_ENABLED = 3'd6;

  localparam logic [POS_W-1:0] MAX_POS_RESET = 16'd4095;

  // 2-bit finger states in the status byte
  localparam logic [1:0] ST_NONE       = 2'd0;
  localparam logic [1:0] ST_PRESENT    = 2'd1;
  localparam logic [1:0] ST_INACCURATE = 2'd2;
  localparam logic [1:0] ST_RESERVED   = 2'd3;

  typedef enum logic [1:0] {
    KIND_CONTACT = 2'd0,
    KIND_MOTION  = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef struct packed {
    logic             swap_xy;
    logic             flip_x;
    logic             flip_y;
    logic [POS_W-1:0] max_x;
    logic [POS_W-1:0] max_y;
    logic             abs_enabled;
    logic             rel_enabled;
  } cfg_t;

  typedef struct packed {
    kind_t                   kind;
    logic [FINGER_IDX_W-1:0] tracking_id;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic [7:0]              pressure;
    logic [3:0]              width_major;
    logic [3:0]              width_minor;
    logic                    orientation;
    logic signed [7:0]       rel_x;
    logic signed [7:0]       rel_y;
    logic [COUNT_W-1:0]      touch_count;
  } result_t;

  // Tracker and counter update produced by one finger slot
  typedef struct packed {
    logic                    trk_we;
    logic [FINGER_IDX_W-1:0] trk_idx;
    logic [1:0]              trk_state;
    logic [COUNT_W-1:0]      count_next;
  } upd_t;

endpackage

// ===== rtl/tcre_cfg.sv =====
// Configuration register file of the touch contact report engine.
`timescale 1ns / 1ps

module tcre_cfg
  import tcre_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.swap_xy     <= 1'b0;
      cfg.flip_x      <= 1'b0;
      cfg.flip_y      <= 1'b0;
      cfg.max_x       <= MAX_POS_RESET;
      cfg.max_y       <= MAX_POS_RESET;
      cfg.abs_enabled <= 1'b1;
      cfg.rel_enabled <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SWAP_XY:     cfg.swap_xy     <= cfg_data[0];
        REG_FLIP_X:      cfg.flip_x      <= cfg_data[0];
        REG_FLIP_Y:      cfg.flip_y      <= cfg_data[0];
        REG_MAX_X:       cfg.max_x       <= cfg_data[POS_W-1:0];
        REG_MAX_Y:       cfg.max_y       <= cfg_data[POS_W-1:0];
        REG_ABS_ENABLED: cfg.abs_enabled <= cfg_data[0];
        REG_REL_ENABLED: cfg.rel_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/tcre_report.sv =====
// Per-slot decode: builds contact, motion and summary results and the tracker update.
`timescale 1ns / 1ps

module tcre_report
  import tcre_pkg::*;
(
  input  cfg_t                    cfg,
  input  logic [FINGER_IDX_W-1:0] finger_index,
  input  logic [7:0]              status_byte,
  input  logic [7:0]              x_high,
  input  logic [7:0]              y_high,
  input  logic [3:0]              x_low,
  input  logic [3:0]              y_low,
  input  logic [3:0]              width_x,
  input  logic [3:0]              width_y,
  input  logic [7:0]              pressure,
  input  logic signed [7:0]       delta_x,
  input  logic signed [7:0]       delta_y,
  input  logic                    last_finger,
  input  logic [1:0]              tracked_state,
  input  logic [COUNT_W-1:0]      pressed_count,
  output result_t                 res [NUM_SLOTS],
  output logic [NUM_SLOTS-1:0]    res_valid,
  output upd_t                    upd
);

  logic [1:0]         st;
  logic               in_range;
  logic               reserved;
  logic               pressed;
  logic [1:0]         prev;
  logic [COUNT_W-1:0] count_inc;
  logic [POS_W-1:0]   x_raw, y_raw, x_sw, y_sw;
  logic [3:0]         wx_sw, wy_sw;
  logic               contact_v, motion_v, summary_v;
  result_t            contact, motion, summary;

  always_comb begin
    case (finger_index[1:0])
      2'd0:    st = status_byte[1:0];
      2'd1:    st = status_byte[3:2];
      2'd2:    st = status_byte[5:4];
      default: st = status_byte[7:6];
    endcase
  end

  assign in_range = finger_index < FINGER_IDX_W'(MAX_FINGERS);
  assign reserved = (st == ST_RESERVED);
  assign pressed  = (st == ST_PRESENT) || (st == ST_INACCURATE);
  assign prev     = in_range ? tracked_state : ST_NONE;

  assign count_inc = (!reserved && pressed && pressed_count < COUNT_MAX) ?
                     pressed_count + COUNT_W'(1) : pressed_count;

  assign x_raw = {4'd0, x_high, x_low};
  assign y_raw = {4'd0, y_high, y_low};
  assign x_sw  = cfg.swap_xy ? y_raw : x_raw;
  assign y_sw  = cfg.swap_xy ? x_raw : y_raw;
  assign wx_sw = cfg.swap_xy ? width_y : width_x;
  assign wy_sw = cfg.swap_xy ? width_x : width_y;

  // Contact report; a release keeps only the tracking id
  always_comb begin
    contact             = '0;
    contact.kind        = KIND_CONTACT;
    contact.tracking_id = finger_index;
    if (st != ST_NONE) begin
      contact.pressure    = pressure;
      contact.width_major = (width_x > width_y) ? width_x : width_y;
      contact.width_minor = (width_x > width_y) ? width_y : width_x;
      contact.orientation = wx_sw > wy_sw;
      if (cfg.flip_x) contact.pos_x = (cfg.max_x >= x_sw) ? cfg.max_x - x_sw : '0;
      else            contact.pos_x = x_sw;
      if (cfg.flip_y) contact.pos_y = (cfg.max_y >= y_sw) ? cfg.max_y - y_sw : '0;
      else            contact.pos_y = y_sw;
    end
  end

  always_comb begin
    motion       = '0;
    motion.kind  = KIND_MOTION;
    motion.rel_x = cfg.swap_xy ? delta_y : delta_x;
    motion.rel_y = cfg.swap_xy ? delta_x : delta_y;
  end

  always_comb begin
    summary             = '0;
    summary.kind        = KIND_SUMMARY;
    summary.touch_count = count_inc;
  end

  assign contact_v = !reserved && cfg.abs_enabled && (prev != ST_NONE || st != ST_NONE);
  assign motion_v  = !reserved && cfg.rel_enabled && (delta_x != 8'sd0 || delta_y != 8'sd0);
  assign summary_v = last_finger;

  // Pack valid results to the front, in contact, motion, summary order
  always_comb begin
    res[0]    = summary;
    res[1]    = summary;
    res[2]    = summary;
    res_valid = '0;
    case ({contact_v, motion_v})
      2'b11: begin
        res[0]    = contact;
        res[1]    = motion;
        res_valid = {summary_v, 2'b11};
      end
      2'b10: begin
        res[0]    = contact;
        res_valid = {1'b0, summary_v, 1'b1};
      end
      2'b01: begin
        res[0]    = motion;
        res_valid = {1'b0, summary_v, 1'b1};
      end
      default: begin
        res_valid = {2'b00, summary_v};
      end
    endcase
  end

  assign upd.trk_we     = !reserved && cfg.abs_enabled && in_range;
  assign upd.trk_idx    = finger_index;
  assign upd.trk_state  = st;
  assign upd.count_next = last_finger ? '0 : count_inc;

endmodule

// ===== rtl/tcre_emit.sv =====
// Result holding register and output register; sends one result per cycle while out_ready is high.
`timescale 1ns / 1ps

module tcre_emit
  import tcre_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_xfer,
  input  result_t              new_res [NUM_SLOTS],
  input  logic [NUM_SLOTS-1:0] new_valid,
  output logic                 can_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output result_t              out_res,
  output logic                 out_last
);

  result_t              pend_res [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] pend_valid;
  logic [NUM_SLOTS-1:0] rest;
  result_t              sel;
  logic                 out_free;
  logic                 move;
  logic                 pend_one;

  always_comb begin
    if (pend_valid[0]) begin
      sel  = pend_res[0];
      rest = {pend_valid[2:1], 1'b0};
    end else if (pend_valid[1]) begin
      sel  = pend_res[1];
      rest = {pend_valid[2], 2'b00};
    end else begin
      sel  = pend_res[2];
      rest = '0;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign move     = out_free && (pend_valid != '0);
  assign pend_one = (pend_valid == 3'b001) || (pend_valid == 3'b010) ||
                    (pend_valid == 3'b100);
  // Take a new slot when the holding register is empty or drains this cycle
  assign can_take = (pend_valid == '0) || (out_free && pend_one);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (in_xfer) pend_valid <= new_valid;
      else if (move) pend_valid <= rest;
      if (move) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) pend_res <= new_res;
    if (move) begin
      out_res  <= sel;
      out_last <= (rest == '0);
    end
  end

  // A result that is not the last of its slot has its successor waiting
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |-> pend_valid != '0)
    else $error("non-final result transferred with nothing pending");

  // The frame summary always closes its slot's results
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.kind == KIND_SUMMARY |-> out_last)
    else $error("summary result not marked last");

  // A new slot never overwrites a pending result that has not moved out
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> $countones(pend_valid) <= 1 && (pend_valid == '0 || move))
    else $error("pending results overwritten");

endmodule

// ===== rtl/touch_contact_report_engine_unit.sv =====
// Flow: a transferred slot's results wait in the holding register, move to the
// output register while it is free, and transfer out from there.
// Rate: one result per cycle from the output register while out_ready is high;
// a slot gives at most 3 results, and the next slot is taken as
// the last result of the current one moves to the output register.
// Reset (synchronous): clears the finger tracker, the frame count, all valid flags,
// and loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module touch_contact_report_engine_unit
  import tcre_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [FINGER_IDX_W-1:0] finger_index,
  input  logic [7:0]              status_byte,
  input  logic [7:0]              x_high,
  input  logic [7:0]              y_high,
  input  logic [3:0]              x_low,
  input  logic [3:0]              y_low,
  input  logic [3:0]              width_x,
  input  logic [3:0]              width_y,
  input  logic [7:0]              pressure,
  input  logic signed [7:0]       delta_x,
  input  logic signed [7:0]       delta_y,
  input  logic                    last_finger,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              report_kind,
  output logic [FINGER_IDX_W-1:0] tracking_id,
  output logic [POS_W-1:0]        pos_x,
  output logic [POS_W-1:0]        pos_y,
  output logic [7:0]              contact_pressure,
  output logic [3:0]              width_major,
  output logic [3:0]              width_minor,
  output logic                    orientation,
  output logic signed [7:0]       rel_x,
  output logic signed [7:0]       rel_y,
  output logic [COUNT_W-1:0]      touch_count,
  output logic                    last_of_run
);

  cfg_t                 cfg;
  logic [1:0]           prior_state [MAX_FINGERS];
  logic [COUNT_W-1:0]   pressed_count;
  logic [1:0]           tracked_state;
  result_t              new_res [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] new_valid;
  upd_t                 upd;
  logic                 in_xfer;
  logic                 can_take;
  result_t              out_res;

  tcre_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Out-of-range slots read ST_NONE here and are also masked inside the decode
  assign tracked_state = (finger_index < FINGER_IDX_W'(MAX_FINGERS)) ?
                         prior_state[finger_index] : ST_NONE;

  tcre_report u_report (
    .cfg           (cfg),
    .finger_index  (finger_index),
    .status_byte   (status_byte),
    .x_high        (x_high),
    .y_high        (y_high),
    .x_low         (x_low),
    .y_low         (y_low),
    .width_x       (width_x),
    .width_y       (width_y),
    .pressure      (pressure),
    .delta_x       (delta_x),
    .delta_y       (delta_y),
    .last_finger   (last_finger),
    .tracked_state (tracked_state),
    .pressed_count (pressed_count),
    .res           (new_res),
    .res_valid     (new_valid),
    .upd           (upd)
  );

  assign in_ready = can_take;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_count <= '0;
      for (int i = 0; i < MAX_FINGERS; i++) prior_state[i] <= ST_NONE;
    end else if (in_xfer) begin
      pressed_count <= upd.count_next;
      if (upd.trk_we) prior_state[upd.trk_idx] <= upd.trk_state;
    end
  end

  tcre_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_xfer   (in_xfer),
    .new_res   (new_res),
    .new_valid (new_valid),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .out_last  (last_of_run)
  );

  assign report_kind      = out_res.kind;
  assign tracking_id      = out_res.tracking_id;
  assign pos_x            = out_res.pos_x;
  assign pos_y            = out_res.pos_y;
  assign contact_pressure = out_res.pressure;
  assign width_major      = out_res.width_major;
  assign width_minor      = out_res.width_minor;
  assign orientation      = out_res.orientation;
  assign rel_x            = out_res.rel_x;
  assign rel_y            = out_res.rel_y;
  assign touch_count      = out_res.touch_count;

endmodule
